// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, sampled on clk_i and off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge out of reset
`define PED_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Expression must never be true out of reset
`define PED_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition seen");

`else

`define PED_ASSERT(lbl, prop)
`define PED_ASSERT_NEVER(lbl, expr)

`endif

`endif

// ----- sv/ped_pkg.sv -----
// ----------------------------------------------------------------------------
// ped_pkg
// Types, character codes and hex helpers for the percent escape decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ped_pkg;

  // Special characters of the escaped stream
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_U       = 8'h75;
  localparam logic [7:0] CH_ZERO    = 8'h30;

  // Number of literal characters held by a full "\u00" prefix
  localparam int unsigned PFX_MAX = 4;

  // Escape parser phase
  typedef enum logic [2:0] {
    PH_PLAIN  = 3'd0,  // plain text
    PH_PCT1   = 3'd1,  // after '%'
    PH_PCT2   = 3'd2,  // after '%' and one character
    PH_BS     = 3'd3,  // after backslash
    PH_BSU    = 3'd4,  // after "\u"
    PH_BSU0   = 3'd5,  // after "\u0"
    PH_BSU00  = 3'd6,  // after "\u00"
    PH_BSU00X = 3'd7   // after "\u00" and one character
  } phase_e;

  // Hex digit value; anything that is not a hex digit reads as zero
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [3:0] n;
    n = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      n = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      n = 4'(c[2:0] + 3'd1) + 4'd8;
    end
    return n;
  endfunction

  function automatic logic [7:0] hex_join(input logic [7:0] hi, input logic [7:0] lo);
    return {hex_nibble(hi), hex_nibble(lo)};
  endfunction

  // Literal character at a given place of the "\u00" prefix
  function automatic logic [7:0] prefix_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = CH_BSLASH;
      2'd1:    c = CH_U;
      default: c = CH_ZERO;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- sv/percent_escape_decoder.sv -----
// ----------------------------------------------------------------------------
// percent_escape_decoder
// Decodes '%hh' and '\u00hh' escapes in a byte stream, one raw byte per item.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+----------------------------------
//  in      | input     | in_valid_i/in_stall_o   | in_byte_i, in_last_i
//  out     | output    | out_valid_o/out_stall_i | out_byte_o, out_has_byte_o,
//          |           |                         | out_last_o
//
//  An input item is decoded in the cycle it is accepted and its results land in
//  the result register; one item per cycle is sustained while out_stall_i is low.
//  A broken or truncated backslash sequence yields up to five results, sent one
//  per cycle while out_stall_i is low; input stalls until the last one goes.
//  in_stall_o lifts in the same cycle the final pending result is taken.
//  rst_ni clears the parser state and result count asynchronously, not the payload.
//
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module percent_escape_decoder (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_last_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            out_has_byte_o,
  output logic            out_last_o
);

  // Parser state
  ped_pkg::phase_e phase_q, phase_d;
  logic [7:0]      held_q, held_d;

  // Result bundle: literal prefix, then an optional tail result
  logic [2:0] rem_q;        // results still to send
  logic [2:0] pos_q;        // index of the result on the port
  logic [2:0] pfx_len_q;    // prefix characters in this bundle
  logic [7:0] tail_byte_q;
  logic       tail_has_q;   // tail carries a byte (else empty end marker)
  logic       last_q;

  // Decode results for the item on the input port
  logic [2:0] pfx_len;
  logic       byte_vld;
  logic [7:0] byte_val;
  logic       marker;
  logic [2:0] rem_new;

  logic in_acc, out_acc;
  logic is_pct, is_bs, plain_emit, seq_match;
  ped_pkg::phase_e plain_phase;

  assign out_valid_o = (rem_q != 3'd0);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign in_stall_o  = out_valid_o && !((rem_q == 3'd1) && !out_stall_i);
  assign in_acc      = in_valid_i && !in_stall_o;

  // Plain-text handling of the incoming byte
  assign is_pct     = (in_byte_i == ped_pkg::CH_PERCENT);
  assign is_bs      = (in_byte_i == ped_pkg::CH_BSLASH);
  assign plain_emit = !is_pct && !(is_bs && !in_last_i);
  assign seq_match  = (phase_q == ped_pkg::PH_BS) ? (in_byte_i == ped_pkg::CH_U)
                                                  : (in_byte_i == ped_pkg::CH_ZERO);

  always_comb begin
    if (is_pct) begin
      plain_phase = in_last_i ? ped_pkg::PH_PLAIN : ped_pkg::PH_PCT1;
    end else if (is_bs && !in_last_i) begin
      plain_phase = ped_pkg::PH_BS;
    end else begin
      plain_phase = ped_pkg::PH_PLAIN;
    end
  end

  // Next phase and held character
  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    unique case (phase_q)
      ped_pkg::PH_PLAIN: begin
        phase_d = plain_phase;
      end
      ped_pkg::PH_PCT1: begin
        held_d  = in_byte_i;
        phase_d = ped_pkg::PH_PCT2;
      end
      ped_pkg::PH_PCT2, ped_pkg::PH_BSU00X: begin
        phase_d = ped_pkg::PH_PLAIN;
      end
      ped_pkg::PH_BSU00: begin
        if (in_last_i) begin
          phase_d = plain_phase;
        end else begin
          held_d  = in_byte_i;
          phase_d = ped_pkg::PH_BSU00X;
        end
      end
      ped_pkg::PH_BS: begin
        phase_d = (seq_match && !in_last_i) ? ped_pkg::PH_BSU : plain_phase;
      end
      ped_pkg::PH_BSU: begin
        phase_d = (seq_match && !in_last_i) ? ped_pkg::PH_BSU0 : plain_phase;
      end
      ped_pkg::PH_BSU0: begin
        phase_d = (seq_match && !in_last_i) ? ped_pkg::PH_BSU00 : plain_phase;
      end
      default: begin
        phase_d = ped_pkg::PH_PLAIN;
      end
    endcase
    // End of stream returns the parser to its reset state
    if (in_last_i) begin
      phase_d = ped_pkg::PH_PLAIN;
      held_d  = 8'h00;
    end
  end

  // Results caused by the incoming byte
  always_comb begin
    pfx_len  = 3'd0;
    byte_vld = 1'b0;
    byte_val = in_byte_i;
    unique case (phase_q)
      ped_pkg::PH_PLAIN: begin
        byte_vld = plain_emit;
      end
      ped_pkg::PH_PCT1: begin
        byte_vld = 1'b0;
      end
      ped_pkg::PH_PCT2, ped_pkg::PH_BSU00X: begin
        byte_vld = 1'b1;
        byte_val = ped_pkg::hex_join(held_q, in_byte_i);
      end
      ped_pkg::PH_BSU00: begin
        if (in_last_i) begin
          pfx_len  = 3'(ped_pkg::PFX_MAX);
          byte_vld = plain_emit;
        end
      end
      ped_pkg::PH_BS, ped_pkg::PH_BSU, ped_pkg::PH_BSU0: begin
        // Mismatch or end: flush "\", "\u" or "\u0" and treat byte as plain
        if (!(seq_match && !in_last_i)) begin
          pfx_len  = 3'(phase_q) - 3'd2;
          byte_vld = plain_emit;
        end
      end
      default: begin
        byte_vld = 1'b0;
      end
    endcase
  end

  assign marker  = in_last_i && (pfx_len == 3'd0) && !byte_vld;
  assign rem_new = pfx_len + {2'b00, byte_vld || marker};

  // Parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ped_pkg::PH_PLAIN;
      held_q  <= 8'h00;
    end else if (in_acc) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

  // Result register: loaded on accept, stepped on each output item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 3'd0;
      pos_q <= 3'd0;
    end else if (in_acc) begin
      rem_q <= rem_new;
      pos_q <= 3'd0;
    end else if (out_acc) begin
      rem_q <= rem_q - 3'd1;
      pos_q <= pos_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pfx_len_q   <= pfx_len;
      tail_byte_q <= byte_vld ? byte_val : 8'h00;
      tail_has_q  <= byte_vld;
      last_q      <= in_last_i;
    end
  end

  // Output port
  always_comb begin
    if (pos_q < pfx_len_q) begin
      out_byte_o     = ped_pkg::prefix_char(pos_q[1:0]);
      out_has_byte_o = 1'b1;
    end else begin
      out_byte_o     = tail_byte_q;
      out_has_byte_o = tail_has_q;
    end
  end

  assign out_last_o = last_q && (rem_q == 3'd1);

  // Checks
  `PED_ASSERT_NEVER(a_rem_range, rem_q > 3'd5)
  `PED_ASSERT(a_acc_when_free, in_acc |-> ((rem_q == 3'd0) || ((rem_q == 3'd1) && out_acc)))
  `PED_ASSERT(a_marker_is_last, (out_valid_o && !out_has_byte_o) |-> out_last_o)
  `PED_ASSERT(a_last_resets, (in_acc && in_last_i) |=> (phase_q == ped_pkg::PH_PLAIN))
  `PED_ASSERT(a_pos_bound, out_valid_o |-> ((pos_q + rem_q) <= (pfx_len_q + 3'd1)))

endmodule

`default_nettype wire

// ----- dv/percent_escape_decoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// percent_escape_decoder_tb
// Self-checking bench for the escape decoder. A short table of hand-picked
// items runs first, then random streams built mostly from well-formed and
// broken escapes. Every accepted item goes through a local decoder model, and
// each result is checked in order against the model, or a typed row's own want.
// ----------------------------------------------------------------------------

module percent_escape_decoder_tb;

  localparam int unsigned DIR_ROWS        = 26;
  localparam int unsigned RAND_ITEMS      = 270;
  localparam int unsigned WATCHDOG_CYCLES = 4000;
  localparam int unsigned TAIL_CYCLES     = 20;

  // Characters used to build hex digits of escapes
  localparam logic [8*22-1:0] HEX_CHARS = "0123456789abcdefABCDEF";

  // One decoded result
  typedef struct packed {
    logic [7:0] data;
    logic       has_data;
    logic       last;
  } dec_out_t;

  // One input item; typed rows carry their own single expected result
  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    logic       typed;
    dec_out_t   want;
  } stim_row_t;

  localparam dec_out_t NO_WANT = '0;

  // Directed items, walked in order
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    // plain bytes right after reset, byte extremes
    '{"A",                 1'b0, 1'b1, '{"A",   1'b1, 1'b0}},
    '{8'h00,               1'b0, 1'b1, '{8'h00, 1'b1, 1'b0}},
    '{8'hFF,               1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0}},
    // "%41"
    '{ped_pkg::CH_PERCENT, 1'b0, 1'b0, NO_WANT},
    '{"4",                 1'b0, 1'b0, NO_WANT},
    '{"1",                 1'b0, 1'b0, NO_WANT},
    // "%fG": mixed case digit, non-hex low nibble
    '{ped_pkg::CH_PERCENT, 1'b0, 1'b0, NO_WANT},
    '{"f",                 1'b0, 1'b0, NO_WANT},
    '{"G",                 1'b0, 1'b0, NO_WANT},
    // "\u00aB"
    '{ped_pkg::CH_BSLASH,  1'b0, 1'b0, NO_WANT},
    '{ped_pkg::CH_U,       1'b0, 1'b0, NO_WANT},
    '{ped_pkg::CH_ZERO,    1'b0, 1'b0, NO_WANT},
    '{ped_pkg::CH_ZERO,    1'b0, 1'b0, NO_WANT},
    '{"a",                 1'b0, 1'b0, NO_WANT},
    '{"B",                 1'b0, 1'b0, NO_WANT},
    // broken backslash: "\x" passes through
    '{ped_pkg::CH_BSLASH,  1'b0, 1'b0, NO_WANT},
    '{"x",                 1'b0, 1'b0, NO_WANT},
    // truncated "\u00" at stream end: five results
    '{ped_pkg::CH_BSLASH,  1'b0, 1'b0, NO_WANT},
    '{ped_pkg::CH_U,       1'b0, 1'b0, NO_WANT},
    '{ped_pkg::CH_ZERO,    1'b0, 1'b0, NO_WANT},
    '{ped_pkg::CH_ZERO,    1'b0, 1'b0, NO_WANT},
    '{"Z",                 1'b1, 1'b0, NO_WANT},
    // stream of a lone '%': empty end marker
    '{ped_pkg::CH_PERCENT, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}},
    // final backslash passes through
    '{ped_pkg::CH_BSLASH,  1'b1, 1'b1, '{ped_pkg::CH_BSLASH, 1'b1, 1'b1}},
    // stream ends one char after '%': escape dropped
    '{ped_pkg::CH_PERCENT, 1'b0, 1'b0, NO_WANT},
    '{"7",                 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i = 8'h00;
  logic       in_last_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       out_has_byte_o;
  logic       out_last_o;

  logic       tail_flush = 1'b0;

  stim_row_t        stim_q[$];
  dec_out_t         decoded_q[$];
  dec_out_t         step_q[$];
  ped_pkg::phase_e  parse_phase = ped_pkg::PH_PLAIN;
  logic [7:0]       held_ch = 8'h00;
  int unsigned      accepted_cnt = 0;
  int unsigned      fail_cnt = 0;
  int unsigned      idle_cnt = 0;
  int unsigned      mid_pause = 0;

  percent_escape_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_byte_i     (in_byte_i),
    .in_last_i     (in_last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .out_has_byte_o(out_has_byte_o),
    .out_last_o    (out_last_o)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Decoder model
  // --------------------------------------------------------------------------

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= "0" && c <= "9") begin
      d = c - "0";
    end else if (c >= "a" && c <= "f") begin
      d = c - "a" + 8'd10;
    end else if (c >= "A" && c <= "F") begin
      d = c - "A" + 8'd10;
    end
    return d[3:0];
  endfunction

  function automatic void emit_char(input logic [7:0] b);
    if (step_q.size() < 5) begin
      step_q.insert(step_q.size(), dec_out_t'{b, 1'b1, 1'b0});
    end
  endfunction

  // plain-text handling, also used for the byte that breaks a sequence
  function automatic void plain_char(input logic [7:0] b, input logic fin);
    if (b == ped_pkg::CH_PERCENT) begin
      parse_phase = fin ? ped_pkg::PH_PLAIN : ped_pkg::PH_PCT1;
    end else if (b == ped_pkg::CH_BSLASH && !fin) begin
      parse_phase = ped_pkg::PH_BS;
    end else begin
      emit_char(b);
      parse_phase = ped_pkg::PH_PLAIN;
    end
  endfunction

  // release the literal "\u00" prefix held so far
  function automatic void flush_held(input ped_pkg::phase_e ph);
    if (ph >= ped_pkg::PH_BS)    emit_char(ped_pkg::CH_BSLASH);
    if (ph >= ped_pkg::PH_BSU)   emit_char(ped_pkg::CH_U);
    if (ph >= ped_pkg::PH_BSU0)  emit_char(ped_pkg::CH_ZERO);
    if (ph >= ped_pkg::PH_BSU00) emit_char(ped_pkg::CH_ZERO);
  endfunction

  // decode one item; results land in step_q
  function automatic void predict_decode(input logic [7:0] b, input logic fin);
    ped_pkg::phase_e ph;
    dec_out_t        tail;
    ph = parse_phase;
    step_q.delete();
    case (ph)
      ped_pkg::PH_PLAIN: plain_char(b, fin);
      ped_pkg::PH_PCT1: begin
        held_ch     = b;
        parse_phase = ped_pkg::PH_PCT2;
      end
      ped_pkg::PH_PCT2, ped_pkg::PH_BSU00X: begin
        emit_char({hex_val(held_ch), hex_val(b)});
        parse_phase = ped_pkg::PH_PLAIN;
      end
      ped_pkg::PH_BSU00: begin
        if (fin) begin
          flush_held(ph);
          plain_char(b, fin);
        end else begin
          held_ch     = b;
          parse_phase = ped_pkg::PH_BSU00X;
        end
      end
      default: begin
        if (b == ((ph == ped_pkg::PH_BS) ? ped_pkg::CH_U : ped_pkg::CH_ZERO) && !fin) begin
          parse_phase = ped_pkg::phase_e'(ph + 3'd1);
        end else begin
          flush_held(ph);
          parse_phase = ped_pkg::PH_PLAIN;
          plain_char(b, fin);
        end
      end
    endcase
    // stream end: mark the final result, empty marker if nothing came out
    if (fin) begin
      if (step_q.size() == 0) begin
        step_q.insert(0, dec_out_t'{8'h00, 1'b0, 1'b1});
      end else begin
        tail      = step_q.pop_back();
        tail.last = 1'b1;
        step_q.insert(step_q.size(), tail);
      end
      parse_phase = ped_pkg::PH_PLAIN;
      held_ch     = 8'h00;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Random streams
  // --------------------------------------------------------------------------

  task automatic add_char(input logic [7:0] b);
    stim_q.insert(stim_q.size(), stim_row_t'{b, 1'b0, 1'b0, NO_WANT});
  endtask

  function automatic logic [7:0] pick_hex();
    logic [7:0] c;
    if ($urandom_range(0, 4) == 0) begin
      c = 8'($urandom_range(0, 255));
    end else begin
      c = HEX_CHARS[8 * $urandom_range(0, 21) +: 8];
    end
    return c;
  endfunction

  task automatic build_random_streams();
    int unsigned tokens;
    int unsigned kind;
    int unsigned plen;
    stim_row_t   row;
    while (stim_q.size() < DIR_ROWS + RAND_ITEMS) begin
      tokens = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 14);
      repeat (tokens) begin
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
          // plain character, printable or any byte
          add_char(($urandom_range(0, 1) == 0) ? 8'($urandom_range(32, 126))
                                               : 8'($urandom_range(0, 255)));
        end else if (kind < 52) begin
          add_char(ped_pkg::CH_PERCENT);
          add_char(pick_hex());
          add_char(pick_hex());
        end else if (kind < 74) begin
          add_char(ped_pkg::CH_BSLASH);
          add_char(ped_pkg::CH_U);
          add_char(ped_pkg::CH_ZERO);
          add_char(ped_pkg::CH_ZERO);
          add_char(pick_hex());
          add_char(pick_hex());
        end else if (kind < 88) begin
          // "\u00" or a shorter prefix of it, followed by one more byte
          plen = $urandom_range(1, 4);
          add_char(ped_pkg::CH_BSLASH);
          if (plen > 1) add_char(ped_pkg::CH_U);
          if (plen > 2) add_char(ped_pkg::CH_ZERO);
          if (plen > 3) add_char(ped_pkg::CH_ZERO);
          add_char(($urandom_range(0, 2) == 0) ? pick_hex() : 8'($urandom_range(0, 255)));
        end else if (kind < 94) begin
          // percent escape left open, later chars complete it
          add_char(ped_pkg::CH_PERCENT);
          if ($urandom_range(0, 1) == 1) add_char(pick_hex());
        end else begin
          // open backslash prefix, may end the stream
          plen = $urandom_range(1, 4);
          add_char(ped_pkg::CH_BSLASH);
          if (plen > 1) add_char(ped_pkg::CH_U);
          if (plen > 2) add_char(ped_pkg::CH_ZERO);
          if (plen > 3) add_char(ped_pkg::CH_ZERO);
        end
      end
      row     = stim_q.pop_back();
      row.fin = 1'b1;
      stim_q.insert(stim_q.size(), row);
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver stall pattern: stretches of free flow, light, heavy and toggling
  // --------------------------------------------------------------------------

  int unsigned rx_mode = 0;
  int unsigned rx_left = 0;
  logic        rx_toggle = 1'b0;

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(16, 96);
    end else begin
      rx_left--;
    end
    rx_toggle = ~rx_toggle;
    if (tail_flush) begin
      out_stall_i <= 1'b0;
    end else begin
      case (rx_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 99) < 30);
        2:       out_stall_i <= ($urandom_range(0, 99) < 75);
        default: out_stall_i <= rx_toggle;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on accepted items, check accepted results, watchdog
  // --------------------------------------------------------------------------

  always @(posedge clk_i) begin
    dec_out_t  want;
    stim_row_t row;
    logic      moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        row   = stim_q[accepted_cnt];
        predict_decode(in_byte_i, in_last_i);
        if (row.typed) begin
          decoded_q.insert(decoded_q.size(), row.want);
        end else begin
          foreach (step_q[i]) decoded_q.insert(decoded_q.size(), step_q[i]);
        end
        accepted_cnt++;
      end
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        if (decoded_q.size() == 0) begin
          $error("result with nothing expected: out_byte %h has_byte %b last %b",
                 out_byte_o, out_has_byte_o, out_last_o);
          fail_cnt++;
        end else begin
          want = decoded_q.pop_front();
          if (out_byte_o !== want.data) begin
            $error("out_byte: expected %h, got %h", want.data, out_byte_o);
            fail_cnt++;
          end
          if (out_has_byte_o !== want.has_data) begin
            $error("out_has_byte: expected %b, got %b", want.has_data, out_has_byte_o);
            fail_cnt++;
          end
          if (out_last_o !== want.last) begin
            $error("out_last: expected %b, got %b", want.last, out_last_o);
            fail_cnt++;
          end
        end
      end
    end
    idle_cnt = moved ? 0 : idle_cnt + 1;
    if (idle_cnt >= WATCHDOG_CYCLES) begin
      $display("percent_escape_decoder regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------

  // hold until the given number of items is in and every result has come
  task automatic await_drained(input int unsigned target);
    do @(posedge clk_i); while (accepted_cnt != target || decoded_q.size() != 0);
  endtask

  initial begin
    int unsigned burst;
    int unsigned gap;
    foreach (DIRECTED[i]) stim_q.insert(stim_q.size(), DIRECTED[i]);
    build_random_streams();
    mid_pause = DIR_ROWS + (stim_q.size() - DIR_ROWS) / 2;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    burst = 0;
    for (int unsigned k = 0; k < stim_q.size(); k++) begin
      if (k == DIR_ROWS || k == mid_pause) begin
        in_valid_i <= 1'b0;
        await_drained(k);
      end else if (burst == 0) begin
        burst = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 8) : $urandom_range(20, 60);
        gap   = $urandom_range(0, 6);
        if (gap != 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      in_valid_i <= 1'b1;
      in_byte_i  <= stim_q[k].ch;
      in_last_i  <= stim_q[k].fin;
      do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
      if (burst != 0) burst--;
    end
    in_valid_i <= 1'b0;

    // drain, then watch for stray results
    await_drained(stim_q.size());
    tail_flush <= 1'b1;
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("percent_escape_decoder regression: pass");
    end else begin
      $display("percent_escape_decoder regression: fail");
    end
    $finish;
  end

endmodule

// ----- percent_escape_decoder.f -----
+incdir+sv
sv/ped_pkg.sv
sv/percent_escape_decoder.sv
dv/percent_escape_decoder_tb.sv
